[hw/rtl/ctl_pkg.sv]
`default_nettype none

package ctl_pkg;

  // Counter widths for line and column tracking
  localparam int LINE_WIDTH   = 16;
  localparam int COLUMN_WIDTH = 16;

  // Bundle queue between lexer and result serializer
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int MAX_RESULTS = 3;

  // Character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_G      = 8'h47;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_COMMENT = 4'd1,
    M_MODWAIT = 4'd2,
    M_DIGIT   = 4'd3,
    M_PATH    = 4'd4,
    M_IDENT   = 4'd5,
    M_QIN     = 4'd6,
    M_QESC    = 4'd7,
    M_QAFTER  = 4'd8
  } mode_t;

  typedef enum logic [1:0] {
    RK_VALUE = 2'd0,
    RK_END   = 2'd1,
    RK_ERROR = 2'd2
  } rkind_t;

  typedef enum logic [2:0] {
    TK_COMMENT  = 3'd0,
    TK_SYMBOL   = 3'd1,
    TK_MODIFIER = 3'd2,
    TK_NUMBER   = 3'd3,
    TK_SIZE     = 3'd4,
    TK_STRING   = 3'd5,
    TK_PATH     = 3'd6,
    TK_IDENT    = 3'd7
  } tok_t;

  typedef enum logic [1:0] {
    EC_INVALID  = 2'd0,
    EC_BAD_ID   = 2'd1,
    EC_UNCLOSED = 2'd2,
    EC_EMPTY    = 2'd3
  } err_t;

  typedef struct packed {
    rkind_t      kind;
    logic [7:0]  vbyte;
    tok_t        tkind;
    err_t        ecode;
    logic [15:0] line;
    logic [15:0] col;
  } res_t;

  // All results caused by one input transaction
  typedef struct packed {
    logic [1:0]           cnt;
    res_t [MAX_RESULTS-1:0] res;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

[hw/rtl/ctl_front.sv]
`default_nettype none

module ctl_front
  import ctl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output logic            push,
  output bundle_t         bundle
);

  mode_t                   mode, mode_next;
  logic [LINE_WIDTH-1:0]   line, line_next, sline, sline_next;
  logic [COLUMN_WIDTH-1:0] col, col_next, scol, scol_next;
  logic                    all_dig, all_dig_next;
  logic                    size_seen, size_seen_next;
  logic                    quote_sq, quote_sq_next;
  logic                    any_seen, any_seen_next;
  logic                    halted, halted_next;
  logic [1:0]              n;
  res_t [MAX_RESULTS-1:0]  res;
  logic                    do_idle;
  logic [7:0]              qc;
  logic                    is_dig, is_suf;

  function automatic logic is_space(logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == CH_SPACE;
  endfunction

  function automatic logic is_term(logic [7:0] c);
    return is_space(c) || c == CH_HASH || c == CH_LBRACE || c == CH_RBRACE ||
           c == CH_SEMI || c == CH_SQUOTE || c == CH_DQUOTE;
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           c == CH_USCORE || c == CH_DOT;
  endfunction

  function automatic logic [COLUMN_WIDTH-1:0] col_inc(logic [COLUMN_WIDTH-1:0] x);
    return (x == {COLUMN_WIDTH{1'b1}}) ? x : x + COLUMN_WIDTH'(1);
  endfunction

  function automatic logic [LINE_WIDTH-1:0] line_inc(logic [LINE_WIDTH-1:0] x);
    return (x == {LINE_WIDTH{1'b1}}) ? x : x + LINE_WIDTH'(1);
  endfunction

  function automatic res_t mk(rkind_t k, logic [7:0] vb, tok_t tk, err_t ec,
                              logic [LINE_WIDTH-1:0] ln, logic [COLUMN_WIDTH-1:0] cl);
    res_t r;
    r.kind  = k;
    r.vbyte = vb;
    r.tkind = tk;
    r.ecode = ec;
    r.line  = 16'(ln);
    r.col   = 16'(cl);
    return r;
  endfunction

  // Hold lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      line      <= LINE_WIDTH'(1);
      col       <= COLUMN_WIDTH'(1);
      sline     <= '0;
      scol      <= '0;
      all_dig   <= 1'b1;
      size_seen <= 1'b0;
      quote_sq  <= 1'b0;
      any_seen  <= 1'b0;
      halted    <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      line      <= line_next;
      col       <= col_next;
      sline     <= sline_next;
      scol      <= scol_next;
      all_dig   <= all_dig_next;
      size_seen <= size_seen_next;
      quote_sq  <= quote_sq_next;
      any_seen  <= any_seen_next;
      halted    <= halted_next;
    end
  end

  // Lex one character or the end marker: close the running token, then lex afresh if needed
  always_comb begin
    mode_next      = mode;
    line_next      = line;
    col_next       = col;
    sline_next     = sline;
    scol_next      = scol;
    all_dig_next   = all_dig;
    size_seen_next = size_seen;
    quote_sq_next  = quote_sq;
    any_seen_next  = any_seen;
    halted_next    = halted;
    n              = 2'd0;
    res            = '0;
    do_idle        = 1'b0;
    qc             = quote_sq ? CH_SQUOTE : CH_DQUOTE;
    is_dig         = text_byte >= 8'h30 && text_byte <= 8'h39;
    is_suf         = text_byte == CH_K || text_byte == CH_M || text_byte == CH_G;

    if (end_of_text) begin
      if (!halted) begin
        if (!any_seen) begin
          res[n] = mk(RK_ERROR, 8'd0, TK_COMMENT, EC_EMPTY, line, col);
          n = n + 2'd1;
        end else begin
          case (mode)
            M_COMMENT: begin
              res[n] = mk(RK_END, 8'd0, TK_COMMENT, EC_INVALID, sline, scol);
              n = n + 2'd1;
            end
            M_MODWAIT: begin
              res[n] = mk(RK_END, 8'd0, TK_MODIFIER, EC_INVALID, sline, scol);
              n = n + 2'd1;
            end
            M_DIGIT: begin
              res[n] = mk(RK_END, 8'd0,
                          all_dig ? TK_NUMBER : (size_seen ? TK_SIZE : TK_STRING),
                          EC_INVALID, sline, scol);
              n = n + 2'd1;
            end
            M_PATH: begin
              res[n] = mk(RK_END, 8'd0, TK_PATH, EC_INVALID, sline, scol);
              n = n + 2'd1;
            end
            M_IDENT: begin
              res[n] = mk(RK_END, 8'd0, TK_IDENT, EC_INVALID, sline, scol);
              n = n + 2'd1;
            end
            M_QAFTER: begin
              res[n] = mk(RK_END, 8'd0, TK_STRING, EC_INVALID, sline, scol);
              n = n + 2'd1;
            end
            M_QIN, M_QESC: begin
              res[n] = mk(RK_ERROR, 8'd0, TK_COMMENT, EC_UNCLOSED, line, col);
              n = n + 2'd1;
            end
            default: ;
          endcase
        end
      end
      // Return to start
      mode_next      = M_IDLE;
      line_next      = LINE_WIDTH'(1);
      col_next       = COLUMN_WIDTH'(1);
      sline_next     = '0;
      scol_next      = '0;
      all_dig_next   = 1'b1;
      size_seen_next = 1'b0;
      quote_sq_next  = 1'b0;
      any_seen_next  = 1'b0;
      halted_next    = 1'b0;
    end else if (!halted) begin
      any_seen_next = 1'b1;
      case (mode)
        M_COMMENT: begin
          if (text_byte == CH_NL) begin
            res[n] = mk(RK_END, 8'd0, TK_COMMENT, EC_INVALID, sline, scol);
            n = n + 2'd1;
            line_next = line_inc(line);
            col_next  = COLUMN_WIDTH'(1);
            mode_next = M_IDLE;
          end else begin
            res[n] = mk(RK_VALUE, text_byte, TK_COMMENT, EC_INVALID, sline, scol);
            n = n + 2'd1;
          end
        end
        M_MODWAIT: begin
          if (text_byte == CH_STAR) begin
            res[n] = mk(RK_VALUE, text_byte, TK_MODIFIER, EC_INVALID, sline, scol);
            n = n + 2'd1;
            col_next = col_inc(col);
            res[n] = mk(RK_END, 8'd0, TK_MODIFIER, EC_INVALID, sline, scol);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            res[n] = mk(RK_END, 8'd0, TK_MODIFIER, EC_INVALID, sline, scol);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_DIGIT, M_PATH, M_IDENT: begin
          if (is_term(text_byte)) begin
            res[n] = mk(RK_END, 8'd0,
                        (mode == M_DIGIT) ?
                          (all_dig ? TK_NUMBER : (size_seen ? TK_SIZE : TK_STRING)) :
                          ((mode == M_PATH) ? TK_PATH : TK_IDENT),
                        EC_INVALID, sline, scol);
            n = n + 2'd1;
            do_idle = 1'b1;
          end else if (mode == M_IDENT && !is_ident(text_byte) && text_byte != CH_DASH) begin
            res[n] = mk(RK_ERROR, 8'd0, TK_COMMENT, EC_BAD_ID, line, col);
            n = n + 2'd1;
            halted_next = 1'b1;
          end else begin
            if (mode == M_DIGIT && !(all_dig && is_dig)) begin
              size_seen_next = all_dig && is_suf;
              all_dig_next   = 1'b0;
            end
            res[n] = mk(RK_VALUE, text_byte,
                        (mode == M_DIGIT) ?
                          (all_dig_next ? TK_NUMBER :
                            (size_seen_next ? TK_SIZE : TK_STRING)) :
                          ((mode == M_PATH) ? TK_PATH : TK_IDENT),
                        EC_INVALID, sline, scol);
            n = n + 2'd1;
            col_next = col_inc(col);
          end
        end
        M_QIN: begin
          if (text_byte == CH_BSLASH) begin
            res[n] = mk(RK_VALUE, text_byte, TK_STRING, EC_INVALID, sline, scol);
            n = n + 2'd1;
            col_next  = col_inc(col);
            mode_next = M_QESC;
          end else if (text_byte == qc) begin
            col_next  = col_inc(col);
            mode_next = M_QAFTER;
          end else begin
            res[n] = mk(RK_VALUE, text_byte, TK_STRING, EC_INVALID, sline, scol);
            n = n + 2'd1;
            if (text_byte == CH_NL) begin
              line_next = line_inc(line);
              col_next  = COLUMN_WIDTH'(1);
            end else begin
              col_next = col_inc(col);
            end
          end
        end
        M_QESC: begin
          res[n] = mk(RK_VALUE, text_byte, TK_STRING, EC_INVALID, sline, scol);
          n = n + 2'd1;
          col_next  = col_inc(col);
          mode_next = M_QIN;
        end
        M_QAFTER: begin
          if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE) begin
            quote_sq_next = text_byte == CH_SQUOTE;
            col_next      = col_inc(col);
            mode_next     = M_QIN;
          end else begin
            res[n] = mk(RK_END, 8'd0, TK_STRING, EC_INVALID, sline, scol);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // Lex the character as the start of a new token
      if (do_idle) begin
        mode_next = M_IDLE;
        if (is_space(text_byte)) begin
          if (text_byte == CH_NL) begin
            line_next = line_inc(line_next);
            col_next  = COLUMN_WIDTH'(1);
          end else begin
            col_next = col_inc(col_next);
          end
        end else if (text_byte == CH_HASH) begin
          sline_next = line_next;
          scol_next  = col_next;
          res[n] = mk(RK_VALUE, text_byte, TK_COMMENT, EC_INVALID, sline_next, scol_next);
          n = n + 2'd1;
          mode_next = M_COMMENT;
        end else if (text_byte == CH_LBRACE || text_byte == CH_RBRACE ||
                     text_byte == CH_SEMI) begin
          sline_next = line_next;
          scol_next  = col_next;
          res[n] = mk(RK_VALUE, text_byte, TK_SYMBOL, EC_INVALID, sline_next, scol_next);
          n = n + 2'd1;
          res[n] = mk(RK_END, 8'd0, TK_SYMBOL, EC_INVALID, sline_next, scol_next);
          n = n + 2'd1;
          col_next = col_inc(col_next);
        end else if (text_byte == CH_TILDE || text_byte == CH_EQUAL) begin
          sline_next = line_next;
          scol_next  = col_next;
          res[n] = mk(RK_VALUE, text_byte, TK_MODIFIER, EC_INVALID, sline_next, scol_next);
          n = n + 2'd1;
          col_next  = col_inc(col_next);
          mode_next = M_MODWAIT;
        end else if (is_dig) begin
          sline_next     = line_next;
          scol_next      = col_next;
          all_dig_next   = 1'b1;
          size_seen_next = 1'b0;
          res[n] = mk(RK_VALUE, text_byte, TK_NUMBER, EC_INVALID, sline_next, scol_next);
          n = n + 2'd1;
          col_next  = col_inc(col_next);
          mode_next = M_DIGIT;
        end else if (text_byte == CH_SLASH || text_byte == CH_DOT) begin
          sline_next = line_next;
          scol_next  = col_next;
          res[n] = mk(RK_VALUE, text_byte, TK_PATH, EC_INVALID, sline_next, scol_next);
          n = n + 2'd1;
          col_next  = col_inc(col_next);
          mode_next = M_PATH;
        end else if (is_ident(text_byte)) begin
          sline_next = line_next;
          scol_next  = col_next;
          res[n] = mk(RK_VALUE, text_byte, TK_IDENT, EC_INVALID, sline_next, scol_next);
          n = n + 2'd1;
          col_next  = col_inc(col_next);
          mode_next = M_IDENT;
        end else if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE) begin
          sline_next    = line_next;
          scol_next     = col_next;
          quote_sq_next = text_byte == CH_SQUOTE;
          col_next      = col_inc(col_next);
          mode_next     = M_QIN;
        end else begin
          res[n] = mk(RK_ERROR, 8'd0, TK_COMMENT, EC_INVALID, line_next, col_next);
          n = n + 2'd1;
          halted_next = 1'b1;
        end
      end
    end
  end

  assign push       = accept && (n != 2'd0);
  assign bundle.cnt = n;
  assign bundle.res = res;

  // A halted lexer stays silent until the end marker
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && halted && !end_of_text) |-> !push)
    else $error("halted lexer produced results");

endmodule

`default_nettype wire

[hw/rtl/ctl_queue.sv]
`default_nettype none

module ctl_queue
  import ctl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t din,
  input  wire logic    pop,
  output bundle_t      head,
  output qstat_t       stat
);

  bundle_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   count;

  // Store incoming bundle
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QPTR_W'(1);
      if (pop)  rptr <= rptr + QPTR_W'(1);
      if (push && !pop)      count <= count + (QPTR_W+1)'(1);
      else if (pop && !push) count <= count - (QPTR_W+1)'(1);
    end
  end

  assign head       = mem[rptr];
  assign stat.full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign stat.empty = count == '0;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!stat.full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

[hw/rtl/ctl_back.sv]
`default_nettype none

module ctl_back
  import ctl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire bundle_t head,
  input  wire qstat_t  stat,
  output logic         pop,
  input  wire logic    result_stall,
  output logic         result_valid,
  output logic [1:0]   result_kind,
  output logic [7:0]   value_byte,
  output logic [2:0]   token_kind,
  output logic [1:0]   error_code,
  output logic [15:0]  pos_line,
  output logic [15:0]  pos_column,
  output logic         last_of_item
);

  logic [1:0] idx;
  res_t       cur;
  logic       take;

  assign cur          = head.res[idx];
  assign result_valid = !stat.empty;
  assign last_of_item = idx == (head.cnt - 2'd1);
  assign take         = result_valid && !result_stall;
  assign pop          = take && last_of_item;

  assign result_kind = cur.kind;
  assign value_byte  = cur.vbyte;
  assign token_kind  = cur.tkind;
  assign error_code  = cur.ecode;
  assign pos_line    = cur.line;
  assign pos_column  = cur.col;

  // Step through the results of the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (take) begin
      idx <= last_of_item ? 2'd0 : idx + 2'd1;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (idx < head.cnt))
    else $error("result index beyond bundle");

  a_idx_zero_idle: assert property (@(posedge clk) disable iff (rst)
    stat.empty |-> (idx == 2'd0))
    else $error("result index not cleared between bundles");

endmodule

`default_nettype wire

[hw/rtl/config_text_lexer.sv]
`default_nettype none

// Streaming lexer for configuration text.
// Input channel (text_valid/text_stall): one character per transaction in
// text_byte, or an end marker when end_of_text is high (text_byte ignored).
// Output channel (result_valid/result_stall): one result per transaction,
// value character, token end or error, with the token start or error
// position. last_of_item marks the final result caused by one input.
// Each character is lexed in the cycle it is accepted; its zero to three
// results go as one bundle into a four-entry queue, which registers them
// before they are offered; results leave at one per cycle while not stalled.
// Input is taken at one character per cycle while the queue has room, so
// sustained throughput is one character per cycle as long as results
// average at most one per character; the output port is the limit beyond.
// text_stall rises only when the queue holds four undelivered bundles.
// When the receiver stalls, the offered result holds steady and the queue
// fills; characters that give no result never enter the queue.
// Reset clears the lexer to line 1, column 1 and empties the queue.
module config_text_lexer
  import ctl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        text_valid,
  output logic             text_stall,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_text,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [1:0]       result_kind,
  output logic [7:0]       value_byte,
  output logic [2:0]       token_kind,
  output logic [1:0]       error_code,
  output logic [15:0]      pos_line,
  output logic [15:0]      pos_column,
  output logic             last_of_item
);

  logic    accept, push, pop;
  bundle_t bundle, head;
  qstat_t  stat;

  assign text_stall = stat.full;
  assign accept     = text_valid && !text_stall;

  ctl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .push        (push),
    .bundle      (bundle)
  );

  ctl_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (bundle),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  ctl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .stat         (stat),
    .pop          (pop),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .value_byte   (value_byte),
    .token_kind   (token_kind),
    .error_code   (error_code),
    .pos_line     (pos_line),
    .pos_column   (pos_column),
    .last_of_item (last_of_item)
  );

endmodule

`default_nettype wire

[dv/config_text_lexer_test.sv]
`default_nettype none

module config_text_lexer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ctl_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 220;

  typedef struct packed {
    rkind_t      kind;
    logic [7:0]  vbyte;
    tok_t        tkind;
    err_t        ecode;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } lexeme_t;

  logic        clk;
  logic        rst;
  logic        text_valid;
  logic        text_stall;
  logic [7:0]  text_byte;
  logic        end_of_text;
  logic        result_valid;
  logic        result_stall;
  logic [1:0]  result_kind;
  logic [7:0]  value_byte;
  logic [2:0]  token_kind;
  logic [1:0]  error_code;
  logic [15:0] pos_line;
  logic [15:0] pos_column;
  logic        last_of_item;

  config_text_lexer dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_kind  (result_kind),
    .value_byte   (value_byte),
    .token_kind   (token_kind),
    .error_code   (error_code),
    .pos_line     (pos_line),
    .pos_column   (pos_column),
    .last_of_item (last_of_item)
  );

  // Lexer shadow state
  mode_t                   lx_mode;
  logic [LINE_WIDTH-1:0]   lx_line;
  logic [LINE_WIDTH-1:0]   tok_line;
  logic [COLUMN_WIDTH-1:0] lx_col;
  logic [COLUMN_WIDTH-1:0] tok_col;
  bit digits_only;
  bit suffix_seen;
  bit single_quote;
  bit saw_byte;
  bit halted;

  lexeme_t lexemes_due[$];
  int      item_results;
  int      fed_items;
  int      mismatches;
  int      idle_pct;
  int      quiet_cycles;

  always #4 clk = ~clk;

  // ---------------------------------------------------------------
  // Lexer prediction
  // ---------------------------------------------------------------
  function automatic void reset_lexer();
    lx_mode      = M_IDLE;
    lx_line      = LINE_WIDTH'(1);
    lx_col       = COLUMN_WIDTH'(1);
    tok_line     = '0;
    tok_col      = '0;
    digits_only  = 1'b1;
    suffix_seen  = 1'b0;
    single_quote = 1'b0;
    saw_byte     = 1'b0;
    halted       = 1'b0;
  endfunction

  function automatic void emit(rkind_t k, logic [7:0] vb, tok_t tk, err_t ec,
                               logic [15:0] ln, logic [15:0] cl);
    lexeme_t r;
    if (item_results < MAX_RESULTS) begin
      r.kind  = k;
      r.vbyte = vb;
      r.tkind = tk;
      r.ecode = ec;
      r.line  = ln;
      r.col   = cl;
      r.last  = 1'b0;
      lexemes_due = {lexemes_due, r};
      item_results++;
    end
  endfunction

  function automatic void put_value(logic [7:0] c, tok_t tk);
    emit(RK_VALUE, c, tk, EC_INVALID, tok_line[15:0], tok_col[15:0]);
  endfunction

  function automatic void put_end(tok_t tk);
    emit(RK_END, 8'd0, tk, EC_INVALID, tok_line[15:0], tok_col[15:0]);
  endfunction

  function automatic void put_error(err_t ec);
    emit(RK_ERROR, 8'd0, TK_COMMENT, ec, lx_line[15:0], lx_col[15:0]);
    halted = 1'b1;
  endfunction

  // Saturating counters
  function automatic void col_inc();
    if (lx_col != {COLUMN_WIDTH{1'b1}}) lx_col++;
  endfunction

  function automatic void new_line();
    if (lx_line != {LINE_WIDTH{1'b1}}) lx_line++;
    lx_col = COLUMN_WIDTH'(1);
  endfunction

  function automatic void mark_start();
    tok_line = lx_line;
    tok_col  = lx_col;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == CH_SPACE;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_term(logic [7:0] c);
    return is_space(c) || c == CH_HASH || c == CH_LBRACE || c == CH_RBRACE ||
           c == CH_SEMI || c == CH_SQUOTE || c == CH_DQUOTE;
  endfunction

  function automatic bit is_ident_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == CH_USCORE || c == CH_DOT;
  endfunction

  function automatic tok_t run_kind();
    if (lx_mode == M_DIGIT) begin
      if (digits_only) return TK_NUMBER;
      else if (suffix_seen) return TK_SIZE;
      else return TK_STRING;
    end else if (lx_mode == M_PATH) begin
      return TK_PATH;
    end
    return TK_IDENT;
  endfunction

  // Lex a byte that arrives between tokens
  function automatic void idle_byte(logic [7:0] c);
    lx_mode = M_IDLE;
    if (is_space(c)) begin
      if (c == CH_NL) new_line();
      else col_inc();
    end else if (c == CH_HASH) begin
      mark_start();
      put_value(c, TK_COMMENT);
      lx_mode = M_COMMENT;
    end else if (c == CH_LBRACE || c == CH_RBRACE || c == CH_SEMI) begin
      mark_start();
      put_value(c, TK_SYMBOL);
      put_end(TK_SYMBOL);
      col_inc();
    end else if (c == CH_TILDE || c == CH_EQUAL) begin
      mark_start();
      put_value(c, TK_MODIFIER);
      col_inc();
      lx_mode = M_MODWAIT;
    end else if (is_digit(c)) begin
      mark_start();
      digits_only = 1'b1;
      suffix_seen = 1'b0;
      put_value(c, TK_NUMBER);
      col_inc();
      lx_mode = M_DIGIT;
    end else if (c == CH_SLASH || c == CH_DOT) begin
      mark_start();
      put_value(c, TK_PATH);
      col_inc();
      lx_mode = M_PATH;
    end else if (is_ident_char(c)) begin
      mark_start();
      put_value(c, TK_IDENT);
      col_inc();
      lx_mode = M_IDENT;
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      mark_start();
      single_quote = (c == CH_SQUOTE);
      col_inc();
      lx_mode = M_QIN;
    end else begin
      put_error(EC_INVALID);
    end
  endfunction

  function automatic void text_step(logic [7:0] c);
    logic [7:0] q;
    q = single_quote ? CH_SQUOTE : CH_DQUOTE;
    case (lx_mode)
      M_COMMENT: begin
        if (c == CH_NL) begin
          put_end(TK_COMMENT);
          new_line();
          lx_mode = M_IDLE;
        end else begin
          put_value(c, TK_COMMENT);
        end
      end
      M_MODWAIT: begin
        if (c == CH_STAR) begin
          put_value(c, TK_MODIFIER);
          col_inc();
          put_end(TK_MODIFIER);
          lx_mode = M_IDLE;
        end else begin
          put_end(TK_MODIFIER);
          idle_byte(c);
        end
      end
      M_DIGIT, M_PATH, M_IDENT: begin
        if (is_term(c)) begin
          put_end(run_kind());
          idle_byte(c);
        end else if (lx_mode == M_IDENT && !is_ident_char(c) && c != CH_DASH) begin
          put_error(EC_BAD_ID);
        end else begin
          // a digit run turns into a size or a string at its first non-digit
          if (lx_mode == M_DIGIT && !(digits_only && is_digit(c))) begin
            suffix_seen = digits_only && (c == CH_K || c == CH_M || c == CH_G);
            digits_only = 1'b0;
          end
          put_value(c, run_kind());
          col_inc();
        end
      end
      M_QIN: begin
        if (c == CH_BSLASH) begin
          put_value(c, TK_STRING);
          col_inc();
          lx_mode = M_QESC;
        end else if (c == q) begin
          col_inc();
          lx_mode = M_QAFTER;
        end else begin
          put_value(c, TK_STRING);
          if (c == CH_NL) new_line();
          else col_inc();
        end
      end
      M_QESC: begin
        put_value(c, TK_STRING);
        col_inc();
        lx_mode = M_QIN;
      end
      M_QAFTER: begin
        if (c == CH_DQUOTE || c == CH_SQUOTE) begin
          single_quote = (c == CH_SQUOTE);
          col_inc();
          lx_mode = M_QIN;
        end else begin
          put_end(TK_STRING);
          idle_byte(c);
        end
      end
      default: idle_byte(c);
    endcase
  endfunction

  // Work out the results of one accepted transaction
  function automatic void predict(logic [7:0] b, logic e);
    item_results = 0;
    fed_items++;
    if (e) begin
      if (!halted) begin
        if (!saw_byte) begin
          put_error(EC_EMPTY);
        end else begin
          case (lx_mode)
            M_COMMENT: put_end(TK_COMMENT);
            M_MODWAIT: put_end(TK_MODIFIER);
            M_DIGIT, M_PATH, M_IDENT: put_end(run_kind());
            M_QAFTER: put_end(TK_STRING);
            M_QIN, M_QESC: put_error(EC_UNCLOSED);
            default: ;
          endcase
        end
      end
      reset_lexer();
    end else if (!halted) begin
      saw_byte = 1'b1;
      text_step(b);
    end
    if (item_results > 0) begin
      lexemes_due[lexemes_due.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  task automatic feed_char(input logic [7:0] b, input logic e);
    int gap;
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      text_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    text_valid  <= 1'b1;
    text_byte   <= b;
    end_of_text <= e;
    do @(posedge clk); while (text_stall);
    predict(b, e);
  endtask

  task automatic feed_end();
    feed_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(0, 25));
    if ($urandom_range(0, 1)) c = c - 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 5))
      0: return 8'd9;
      1: return CH_NL;
      2: return 8'd11;
      3: return 8'd12;
      4: return 8'd13;
      default: return CH_SPACE;
    endcase
  endfunction

  // One mostly well-formed token with random content
  task automatic feed_random_token();
    logic [7:0] c;
    logic [7:0] q;
    int parts;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0: feed_char(CH_LBRACE, 1'b0);
          1: feed_char(CH_RBRACE, 1'b0);
          default: feed_char(CH_SEMI, 1'b0);
        endcase
      end
      1: begin
        feed_char(CH_HASH, 1'b0);
        repeat ($urandom_range(0, 5)) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_NL) c = CH_SPACE;
          feed_char(c, 1'b0);
        end
        if ($urandom_range(0, 3) != 0) feed_char(CH_NL, 1'b0);
      end
      2: begin
        feed_char($urandom_range(0, 1) ? CH_TILDE : CH_EQUAL, 1'b0);
        if ($urandom_range(0, 1)) feed_char(CH_STAR, 1'b0);
      end
      3: repeat ($urandom_range(1, 4)) feed_char(rand_digit(), 1'b0);
      4: begin
        repeat ($urandom_range(1, 3)) feed_char(rand_digit(), 1'b0);
        case ($urandom_range(0, 2))
          0: feed_char(CH_K, 1'b0);
          1: feed_char(CH_M, 1'b0);
          default: feed_char(CH_G, 1'b0);
        endcase
        // trailing junk turns a size into a plain string
        if ($urandom_range(0, 3) == 0)
          feed_char($urandom_range(0, 1) ? rand_letter() : rand_digit(), 1'b0);
      end
      5: begin
        feed_char($urandom_range(0, 1) ? CH_SLASH : CH_DOT, 1'b0);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 4))
            0: c = rand_digit();
            1: c = CH_SLASH;
            2: c = CH_DASH;
            3: c = 8'($urandom_range(128, 255));
            default: c = rand_letter();
          endcase
          feed_char(c, 1'b0);
        end
      end
      6: begin
        feed_char($urandom_range(0, 3) == 0 ? CH_USCORE : rand_letter(), 1'b0);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 2))
              0: c = rand_digit();
              1: c = 8'($urandom_range(128, 255));
              default: c = "@";
            endcase
          end else begin
            case ($urandom_range(0, 5))
              0: c = CH_DASH;
              1: c = CH_DOT;
              2: c = CH_USCORE;
              default: c = rand_letter();
            endcase
          end
          feed_char(c, 1'b0);
        end
      end
      7, 8: begin
        parts = $urandom_range(1, 3);
        repeat (parts) begin
          q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
          feed_char(q, 1'b0);
          repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 9))
              0: begin
                feed_char(CH_BSLASH, 1'b0);
                feed_char(8'($urandom_range(0, 255)), 1'b0);
              end
              1: feed_char(CH_NL, 1'b0);
              default: begin
                c = 8'($urandom_range(32, 126));
                if (c == q || c == CH_BSLASH) c = "x";
                feed_char(c, 1'b0);
              end
            endcase
          end
          // now and then leave the quote open
          if ($urandom_range(0, 9) != 0) feed_char(q, 1'b0);
        end
      end
      default: feed_char(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  task automatic feed_random_text();
    repeat ($urandom_range(0, 10)) begin
      feed_random_token();
      if ($urandom_range(0, 99) < 60) feed_char(rand_space(), 1'b0);
    end
    feed_end();
  endtask

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_empty_text();
    feed_end();
    feed_end();
  endtask

  task automatic test_symbols_and_comments();
    feed_char(CH_HASH, 1'b0);
    feed_char(8'h00, 1'b0);
    feed_char(8'hFF, 1'b0);
    feed_char(CH_NL, 1'b0);
    feed_char(CH_LBRACE, 1'b0);
    feed_char(CH_TILDE, 1'b0);
    feed_char(CH_STAR, 1'b0);
    feed_char(CH_EQUAL, 1'b0);
    feed_char("5", 1'b0);
    feed_char(CH_K, 1'b0);
    feed_char(CH_SEMI, 1'b0);
    feed_end();
  endtask

  task automatic test_runs_and_quotes();
    feed_char("7", 1'b0);
    feed_char("x", 1'b0);
    feed_char(CH_SPACE, 1'b0);
    feed_char(CH_SLASH, 1'b0);
    feed_char(CH_DQUOTE, 1'b0);
    feed_char("a", 1'b0);
    feed_char(CH_BSLASH, 1'b0);
    feed_char(CH_DQUOTE, 1'b0);
    feed_char(CH_DQUOTE, 1'b0);
    feed_char(CH_SQUOTE, 1'b0);
    feed_char("b", 1'b0);
    feed_char(CH_SQUOTE, 1'b0);
    feed_end();
  endtask

  task automatic test_errors();
    // bad byte inside an identifier, then ignored input
    feed_char("a", 1'b0);
    feed_char(CH_DASH, 1'b0);
    feed_char(8'h80, 1'b0);
    feed_char("z", 1'b0);
    feed_end();
    // invalid byte between tokens
    feed_char("@", 1'b0);
    feed_end();
    // text ends right after an escape
    feed_char(CH_DQUOTE, 1'b0);
    feed_char(CH_BSLASH, 1'b0);
    feed_end();
  endtask

  task automatic test_line_column_count();
    feed_char(CH_SPACE, 1'b0);
    feed_char(8'd9, 1'b0);
    feed_char("a", 1'b0);
    feed_char(CH_NL, 1'b0);
    feed_char(CH_NL, 1'b0);
    feed_char(CH_SPACE, 1'b0);
    feed_char("7", 1'b0);
    feed_end();
  endtask

  task automatic test_random_texts();
    int base;
    int done;
    base = fed_items;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      // hold a stretch with no idling on either side
      idle_pct = (done >= 100 && done < 160) ? 0 : 25;
      feed_random_text();
      done = fed_items - base;
    end
    idle_pct = 25;
  endtask

  // ---------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    lexeme_t want;
    if (!rst && result_valid && !result_stall) begin
      if (lexemes_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0d",
                 $time, result_kind);
        mismatches++;
      end else begin
        want = lexemes_due.pop_front();
        check_field("result_kind", 16'(want.kind), 16'(result_kind));
        check_field("value_byte", 16'(want.vbyte), 16'(value_byte));
        check_field("token_kind", 16'(want.tkind), 16'(token_kind));
        check_field("error_code", 16'(want.ecode), 16'(error_code));
        check_field("pos_line", want.line, pos_line);
        check_field("pos_column", want.col, pos_column);
        check_field("last_of_item", 16'(want.last), 16'(last_of_item));
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    result_stall <= (idle_pct != 0) && ($urandom_range(0, 99) < idle_pct);
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin : watchdog
    if (rst || (text_valid && !text_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    text_valid   = 1'b0;
    text_byte    = 8'd0;
    end_of_text  = 1'b0;
    result_stall = 1'b0;
    mismatches   = 0;
    fed_items    = 0;
    item_results = 0;
    quiet_cycles = 0;
    idle_pct     = 25;
    reset_lexer();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_text();
    test_symbols_and_comments();
    test_runs_and_quotes();
    test_errors();
    test_line_column_count();
    test_random_texts();

    // drain outstanding results, then let the pipeline settle
    @(negedge clk);
    text_valid <= 1'b0;
    while (lexemes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

[config_text_lexer.f]
hw/rtl/ctl_pkg.sv
hw/rtl/ctl_front.sv
hw/rtl/ctl_queue.sv
hw/rtl/ctl_back.sv
hw/rtl/config_text_lexer.sv
dv/config_text_lexer_test.sv
